// ===== sv/ctsg_pkg.sv =====
// ----------------------------------------------------------------------------
// ctsg_pkg
// Shared types and constants for the coupled two-axis step generator.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package ctsg_pkg;

    localparam int START1_DEF   = 800;
    localparam int START2_DEF   = 1600;
    localparam int POS_BITS_DEF = 14;

    typedef enum logic
    {
        CMD_LOAD = 1'b0,
        CMD_STEP = 1'b1
    } cmd_t;

    // one result item
    typedef struct packed
    {
        logic m1_pulse;
        logic m1_direction;
        logic m2_pulse;
        logic m2_direction;
        logic last;
        logic done_res;
    } res_t;

    // what one step item produces: up to two result items
    typedef struct packed
    {
        res_t       r0;
        res_t       r1;
        logic [1:0] count;
    } step_out_t;

endpackage

// ===== sv/ctsg_step.sv =====
// ----------------------------------------------------------------------------
// ctsg_step
// One stepping pass: compares both joints with their goals, builds the pulse
// items and the positions after the pass.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ctsg_step
#(
    parameter int POS_BITS = ctsg_pkg::POS_BITS_DEF
)
(
    input  logic signed [POS_BITS-1:0] pos1,
    input  logic signed [POS_BITS-1:0] pos2,
    input  logic signed [POS_BITS-1:0] goal1,
    input  logic signed [POS_BITS-1:0] goal2,
    output logic signed [POS_BITS-1:0] pos1_next,
    output logic signed [POS_BITS-1:0] pos2_next,
    output ctsg_pkg::step_out_t        step
);

    import ctsg_pkg::*;

    logic eq1;
    logic eq2;
    logic up1;
    logic up2;
    res_t coupled;
    res_t single;
    res_t done_item;

    assign eq1 = (pos1 == goal1);
    assign eq2 = (pos2 == goal2);
    assign up1 = (goal1 > pos1);
    assign up2 = (goal2 > pos2);

    assign pos1_next = eq1 ? pos1 : (up1 ? pos1 + POS_BITS'(1) : pos1 - POS_BITS'(1));
    assign pos2_next = eq2 ? pos2 : (up2 ? pos2 + POS_BITS'(1) : pos2 - POS_BITS'(1));

    always_comb
    begin
        // joint 2 rides on joint 1, so both motors turn together
        coupled = '{m1_pulse: 1'b1, m1_direction: up1, m2_pulse: 1'b1,
                    m2_direction: up1, last: eq2, done_res: 1'b0};
        single  = '{m1_pulse: 1'b0, m1_direction: 1'b0, m2_pulse: 1'b1,
                    m2_direction: up2, last: 1'b1, done_res: 1'b0};
        done_item = '{m1_pulse: 1'b0, m1_direction: 1'b0, m2_pulse: 1'b0,
                      m2_direction: 1'b0, last: 1'b1, done_res: 1'b1};
    end

    always_comb
    begin
        priority if (eq1 && eq2)
        begin
            step.r0    = done_item;
            step.r1    = single;
            step.count = 2'd1;
        end
        else if (!eq1)
        begin
            step.r0    = coupled;
            step.r1    = single;
            step.count = eq2 ? 2'd1 : 2'd2;
        end
        else
        begin
            step.r0    = single;
            step.r1    = single;
            step.count = 2'd1;
        end
    end

endmodule

// ===== sv/coupled_two_axis_step_generator.sv =====
// ----------------------------------------------------------------------------
// coupled_two_axis_step_generator
// Steps two coupled joints toward loaded targets. A load item stores new
// targets and gives no result. A step item moves joint 1 one microstep toward
// its target (pulsing both motors, since joint 2 is coupled), then joint 2
// one microstep toward its own, giving one result item per pulse; when both
// are on target it gives one result with done_res set. Positions and goals
// update in the cycle the item is accepted, and results go to a two-entry
// result buffer that feeds the output. An item that causes at most one
// result is taken every cycle while the output drains; a step item that
// causes two results occupies the single output port for both, so the
// input stalls while both results are buffered.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module coupled_two_axis_step_generator
#(
    parameter int POS_BITS = ctsg_pkg::POS_BITS_DEF,
    parameter int START1   = ctsg_pkg::START1_DEF,
    parameter int START2   = ctsg_pkg::START2_DEF
)
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    output logic                       in_stall,
    input  logic                       command,
    input  logic signed [POS_BITS-1:0] m1_target,
    input  logic signed [POS_BITS-1:0] m2_target,
    output logic                       out_valid,
    input  logic                       out_stall,
    output logic                       m1_pulse,
    output logic                       m1_direction,
    output logic                       m2_pulse,
    output logic                       m2_direction,
    output logic                       last,
    output logic                       done_res
);

    import ctsg_pkg::*;

    logic signed [POS_BITS-1:0] pos1_reg;
    logic signed [POS_BITS-1:0] pos2_reg;
    logic signed [POS_BITS-1:0] goal1_reg;
    logic signed [POS_BITS-1:0] goal2_reg;
    logic signed [POS_BITS-1:0] pos1_next;
    logic signed [POS_BITS-1:0] pos2_next;
    step_out_t                  step;

    res_t       slot0_reg;
    res_t       slot1_reg;
    logic [1:0] cnt_reg;
    logic [1:0] cnt_next;

    logic in_acc;
    logic out_acc;
    logic is_step;

    ctsg_step
    #(
        .POS_BITS (POS_BITS)
    )
    u_step
    (
        .pos1      (pos1_reg),
        .pos2      (pos2_reg),
        .goal1     (goal1_reg),
        .goal2     (goal2_reg),
        .pos1_next (pos1_next),
        .pos2_next (pos2_next),
        .step      (step)
    );

    assign out_valid = (cnt_reg != 2'd0);
    assign out_acc   = out_valid && !out_stall;
    // buffer must be empty after this cycle's pop to take a new item
    assign in_stall  = (cnt_reg == 2'd2) || ((cnt_reg == 2'd1) && out_stall);
    assign in_acc    = in_valid && !in_stall;
    assign is_step   = (command == CMD_STEP);

    assign m1_pulse     = slot0_reg.m1_pulse;
    assign m1_direction = slot0_reg.m1_direction;
    assign m2_pulse     = slot0_reg.m2_pulse;
    assign m2_direction = slot0_reg.m2_direction;
    assign last         = slot0_reg.last;
    assign done_res     = slot0_reg.done_res;

    always_comb
    begin
        cnt_next = cnt_reg;
        if (out_acc)
        begin
            cnt_next = cnt_reg - 2'd1;
        end
        if (in_acc && is_step)
        begin
            cnt_next = step.count;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos1_reg  <= POS_BITS'(START1);
            pos2_reg  <= POS_BITS'(START2);
            goal1_reg <= POS_BITS'(START1);
            goal2_reg <= POS_BITS'(START2);
            cnt_reg   <= 2'd0;
        end
        else
        begin
            cnt_reg <= cnt_next;
            if (in_acc)
            begin
                if (is_step)
                begin
                    pos1_reg <= pos1_next;
                    pos2_reg <= pos2_next;
                end
                else
                begin
                    goal1_reg <= m1_target;
                    goal2_reg <= m2_target;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_acc && is_step)
        begin
            slot0_reg <= step.r0;
            slot1_reg <= step.r1;
        end
        else if (out_acc)
        begin
            slot0_reg <= slot1_reg;
        end
    end

    // ------------------------------------------------------------------------
    // assertions
    // ------------------------------------------------------------------------
    a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg != 2'd3)
        else $error("result buffer count out of range");

    a_step_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall && command == CMD_STEP) |=> out_valid)
        else $error("step item gave no result");

    a_coupled: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && m1_pulse) |-> (m2_pulse && m2_direction == m1_direction
                                     && !done_res))
        else $error("joint 1 pulse not coupled to motor 2");

    a_done_item: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && done_res) |-> (last && !m1_pulse && !m2_pulse))
        else $error("done item malformed");

endmodule
